FILE: rtl/biquad_tdf2_multichannel_filter_assert.svh
// Assertion macros shared by the biquad RTL.
// Both expect a signal named clk in the calling scope; BQ_ASSERT also expects rst_n.
`ifndef BIQUAD_TDF2_MULTICHANNEL_FILTER_ASSERT_SVH
`define BIQUAD_TDF2_MULTICHANNEL_FILTER_ASSERT_SVH

// Check a property outside reset.
`define BQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("biquad assertion failed");

// Check a property on every edge, reset included.
`define BQ_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("biquad reset assertion failed");

`endif

FILE: rtl/bqtdf2_pkg.sv
package bqtdf2_pkg;

  // Coefficient register width and the lane's sign-extended coefficient width
  localparam int COEF_W      = 32;
  localparam int LANE_COEF_W = COEF_W + 1;
  // Upper accumulator width of a lane; the full accumulator is SAMPLE_BITS + HI_W
  localparam int HI_W        = COEF_W + 2;
  // Extra bits of the delay state over the sample width
  localparam int STATE_EXTRA = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // Per-cycle control of one multiply-accumulate lane
  typedef struct packed {
    logic load;  // take coefficient, multiplier and addend
    logic step;  // consume one multiplier bit
    logic neg;   // this step is the multiplier's sign bit
    logic fold;  // add the remaining upper addend bits
  } lane_ctl_t;

endpackage

FILE: rtl/bqtdf2_mac_lane.sv
// Bit-serial multiply-accumulate: result = coef * mult + addend.
// One multiplier bit per step, LSB first; the addend enters one bit per step
// as a carry, and its upper part is folded in on a final cycle.
module bqtdf2_mac_lane #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                              clk,
  input  bqtdf2_pkg::lane_ctl_t                             ctl,
  input  logic [bqtdf2_pkg::LANE_COEF_W-1:0]                coef,
  input  logic [SAMPLE_BITS-1:0]                            mult,
  input  logic [SAMPLE_BITS+bqtdf2_pkg::HI_W-1:0]           addend,
  output logic [SAMPLE_BITS+bqtdf2_pkg::HI_W-1:0]           result
);

  localparam int HW = bqtdf2_pkg::HI_W;
  localparam int CW = bqtdf2_pkg::LANE_COEF_W;
  localparam int W  = SAMPLE_BITS + HW;

  logic [HW-1:0]          h_r;
  logic [SAMPLE_BITS-1:0] l_r;
  logic [SAMPLE_BITS-1:0] m_r;
  logic [W-1:0]           a_r;
  logic [CW-1:0]          c_r;

  logic [HW:0]   c_ext;
  logic [HW:0]   term;
  logic [HW:0]   h_sum;
  logic [HW-1:0] h_fold;

  // Partial product for this bit; the sign bit of the multiplier weighs negative
  always_comb begin
    c_ext = {{(HW + 1 - CW){c_r[CW-1]}}, c_r};
    if (!m_r[0]) begin
      term = '0;
    end else if (ctl.neg) begin
      term = (HW + 1)'(0) - c_ext;
    end else begin
      term = c_ext;
    end
    h_sum  = {h_r[HW-1], h_r} + term + (HW + 1)'(a_r[0]);
    h_fold = h_r + a_r[HW-1:0];
  end

  // Load operands, shift one bit per step, fold the upper addend last
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      h_r <= '0;
      l_r <= '0;
      m_r <= mult;
      a_r <= addend;
      c_r <= coef;
    end else if (ctl.step) begin
      h_r <= h_sum[HW:1];
      l_r <= {h_sum[0], l_r[SAMPLE_BITS-1:1]};
      m_r <= {1'b0, m_r[SAMPLE_BITS-1:1]};
      a_r <= {a_r[W-1], a_r[W-1:1]};
    end else if (ctl.fold) begin
      h_r <= h_fold;
    end
  end

  assign result = {h_r, l_r};

endmodule

FILE: rtl/bqtdf2_delay_store.sv
// Per-channel delay pair of the transposed section, cleared at reset.
module bqtdf2_delay_store #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_idx,
  input  logic                                               wr_en,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_idx,
  input  logic [SAMPLE_BITS+bqtdf2_pkg::STATE_EXTRA-1:0]     wr_one,
  input  logic [SAMPLE_BITS+bqtdf2_pkg::STATE_EXTRA-1:0]     wr_two,
  output logic [SAMPLE_BITS+bqtdf2_pkg::STATE_EXTRA-1:0]     rd_one,
  output logic [SAMPLE_BITS+bqtdf2_pkg::STATE_EXTRA-1:0]     rd_two
);

  localparam int SB = SAMPLE_BITS + bqtdf2_pkg::STATE_EXTRA;

  logic [SB-1:0] one_r [CHANNELS];
  logic [SB-1:0] two_r [CHANNELS];

  // Clear every channel at reset, update the selected channel on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        one_r[i] <= '0;
        two_r[i] <= '0;
      end
    end else if (wr_en) begin
      one_r[wr_idx] <= wr_one;
      two_r[wr_idx] <= wr_two;
    end
  end

  assign rd_one = one_r[rd_idx];
  assign rd_two = two_r[rd_idx];

endmodule

FILE: rtl/biquad_tdf2_multichannel_filter.sv
// The bit-serial lanes compute each item in turn: the b terms on x, then the a terms
// on y, then write back, which waits while the output register is still full.
// A new item is accepted only in idle, after the previous one was written back.
// A finished item waits in the output register; the next item is taken meanwhile.
// Reset (rst_n low, synchronous) clears both delay stores of every channel and
// returns coefficients to b0 = 1.0, all others 0.
`include "biquad_tdf2_multichannel_filter_assert.svh"

module biquad_tdf2_multichannel_filter #(
  parameter int CHANNELS       = 2,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 27
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,   // sample_in
  input  logic                                   in_tuser,   // channel_in
  // Result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] out_tdata,  // sample_out
  output logic                                   out_tuser,  // channel_out
  // Configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bqtdf2_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bqtdf2_pkg::COEF_W-1:0]          cfg_data
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int HW     = bqtdf2_pkg::HI_W;
  localparam int W      = SAMPLE_BITS + HW;
  localparam int SB     = SAMPLE_BITS + bqtdf2_pkg::STATE_EXTRA;
  localparam int CW     = bqtdf2_pkg::LANE_COEF_W;
  localparam int QW     = W - COEF_FRAC_BITS + 1;
  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(SAMPLE_BITS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MULX  = 3'd1;
  localparam logic [2:0] ST_Y     = 3'd2;
  localparam logic [2:0] ST_MULY  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_BITS);
  localparam logic [CNT_W-1:0] CNT_SIGN = CNT_W'(SAMPLE_BITS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] ch_r;
  logic             chan_r;

  logic [bqtdf2_pkg::COEF_W-1:0] coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;

  logic out_tvalid_r;
  logic [SAMPLE_BITS-1:0] sample_out_r;
  logic chan_out_r;

  bqtdf2_pkg::lane_ctl_t ctl0, ctl12;
  logic             st_we;
  logic             out_load;
  logic [IDX_W-1:0] rd_idx;
  logic [SB-1:0]    rd_one, rd_two;
  logic [W-1:0]     res0, res1, res2;
  logic [CW-1:0]    coef1, coef2;
  logic [SAMPLE_BITS-1:0] mult12;
  logic [W-1:0]     add1, add2;
  logic [QW-1:0]    y_q;
  logic [SAMPLE_BITS-1:0] y_nxt;
  logic [SB-1:0]    r1_sat, r2_sat;

  // Configuration registers; writes to unused indexes fall through
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r <= bqtdf2_pkg::COEF_W'(64'd1 << COEF_FRAC_BITS);
      coef_b1_r <= '0;
      coef_b2_r <= '0;
      coef_a1_r <= '0;
      coef_a2_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bqtdf2_pkg::REG_B0: coef_b0_r <= cfg_data;
        bqtdf2_pkg::REG_B1: coef_b1_r <= cfg_data;
        bqtdf2_pkg::REG_B2: coef_b2_r <= cfg_data;
        bqtdf2_pkg::REG_A1: coef_a1_r <= cfg_data;
        bqtdf2_pkg::REG_A2: coef_a2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Map the channel to its delay pair
  assign rd_idx = (CHANNELS > 1) ? IDX_W'(in_tuser) : '0;

  bqtdf2_delay_store #(
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_idx(rd_idx),
    .wr_en (st_we),
    .wr_idx(ch_r),
    .wr_one(r1_sat),
    .wr_two(r2_sat),
    .rd_one(rd_one),
    .rd_two(rd_two)
  );

  // Round half up and saturate y from the b0 lane
  always_comb begin
    y_q = {res0[W-1], res0[W-1:COEF_FRAC_BITS]} + QW'(res0[COEF_FRAC_BITS-1]);
    if ((&y_q[QW-1:SAMPLE_BITS-1]) || !(|y_q[QW-1:SAMPLE_BITS-1])) begin
      y_nxt = y_q[SAMPLE_BITS-1:0];
    end else if (y_q[QW-1]) begin
      y_nxt = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      y_nxt = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end
  end

  // Saturate new delay values to the state width
  always_comb begin
    if ((&res1[W-1:SB-1]) || !(|res1[W-1:SB-1])) begin
      r1_sat = res1[SB-1:0];
    end else begin
      r1_sat = {res1[W-1], {(SB - 1){~res1[W-1]}}};
    end
    if ((&res2[W-1:SB-1]) || !(|res2[W-1:SB-1])) begin
      r2_sat = res2[SB-1:0];
    end else begin
      r2_sat = {res2[W-1], {(SB - 1){~res2[W-1]}}};
    end
  end

  // Lanes 1 and 2 run the b terms on x, then accumulate the negated a terms on y
  always_comb begin
    if (state_r == ST_IDLE) begin
      coef1  = {coef_b1_r[bqtdf2_pkg::COEF_W-1], coef_b1_r};
      coef2  = {coef_b2_r[bqtdf2_pkg::COEF_W-1], coef_b2_r};
      mult12 = in_tdata[SAMPLE_BITS-1:0];
      add1   = {{(W - SB){rd_two[SB-1]}}, rd_two};
      add2   = '0;
    end else begin
      coef1  = CW'(0) - {coef_a1_r[bqtdf2_pkg::COEF_W-1], coef_a1_r};
      coef2  = CW'(0) - {coef_a2_r[bqtdf2_pkg::COEF_W-1], coef_a2_r};
      mult12 = y_nxt;
      add1   = res1;
      add2   = res2;
    end
  end

  bqtdf2_mac_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane0 (
    .clk   (clk),
    .ctl   (ctl0),
    .coef  ({coef_b0_r[bqtdf2_pkg::COEF_W-1], coef_b0_r}),
    .mult  (in_tdata[SAMPLE_BITS-1:0]),
    .addend({{(W - SB){rd_one[SB-1]}}, rd_one}),
    .result(res0)
  );

  bqtdf2_mac_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane1 (
    .clk   (clk),
    .ctl   (ctl12),
    .coef  (coef1),
    .mult  (mult12),
    .addend(add1),
    .result(res1)
  );

  bqtdf2_mac_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane2 (
    .clk   (clk),
    .ctl   (ctl12),
    .coef  (coef2),
    .mult  (mult12),
    .addend(add2),
    .result(res2)
  );

  // Sequencer: accept, x pass, y, y pass, write back
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl0      = '0;
    ctl12     = '0;
    st_we     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ctl0.load  = 1'b1;
          ctl12.load = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = ST_MULX;
        end
      end
      ST_MULX: begin
        if (cnt_r == CNT_LAST) begin
          ctl0.fold  = 1'b1;
          ctl12.fold = 1'b1;
          state_nxt  = ST_Y;
        end else begin
          ctl0.step  = 1'b1;
          ctl0.neg   = (cnt_r == CNT_SIGN);
          ctl12.step = 1'b1;
          ctl12.neg  = (cnt_r == CNT_SIGN);
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      ST_Y: begin
        ctl12.load = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = ST_MULY;
      end
      ST_MULY: begin
        if (cnt_r == CNT_LAST) begin
          ctl12.fold = 1'b1;
          state_nxt  = ST_WRITE;
        end else begin
          ctl12.step = 1'b1;
          ctl12.neg  = (cnt_r == CNT_SIGN);
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      ST_WRITE: begin
        if (!out_tvalid_r || out_tready) begin
          st_we     = 1'b1;
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold the item's channel; the b0 lane keeps y until write back
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      ch_r   <= rd_idx;
      chan_r <= in_tuser;
    end
    if (out_load) begin
      sample_out_r <= y_nxt;
      chan_out_r   <= chan_r;
    end
  end

  // Output register: set on write back, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = DATA_W'(sample_out_r);
  assign out_tuser  = chan_out_r;

  `BQ_ASSERT(a_busy_after_accept, (in_tvalid && in_tready) |=> !in_tready)
  `BQ_ASSERT(a_out_from_write, $rose(out_tvalid) |-> $past(state_r == ST_WRITE))
  `BQ_ASSERT(a_cnt_bound, (state_r == ST_MULX || state_r == ST_MULY) |-> (cnt_r <= CNT_LAST))
  `BQ_ASSERT_RST(a_reset_idle, !rst_n |=> (!out_tvalid && in_tready))

endmodule

FILE: dv/biquad_tdf2_multichannel_filter_test.sv
module biquad_tdf2_multichannel_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COEF_W = bqtdf2_pkg::COEF_W;
  localparam int CFG_IDX_W = bqtdf2_pkg::CFG_IDX_W;
  localparam logic [CFG_IDX_W-1:0] REG_B0 = bqtdf2_pkg::REG_B0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = bqtdf2_pkg::REG_B1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = bqtdf2_pkg::REG_B2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = bqtdf2_pkg::REG_A1;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = bqtdf2_pkg::REG_A2;

  localparam int SAMPLE_W = 24;
  localparam int DATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int FRAC_W = 27;
  localparam int STATE_W = SAMPLE_W + bqtdf2_pkg::STATE_EXTRA;
  localparam int LATENCY = 2 * SAMPLE_W + 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 56;
  localparam int NUM_ROWS = 40;

  // Coefficient words, Q4.27
  localparam logic [COEF_W-1:0] TAP_ONE = 32'h0800_0000;
  localparam logic [COEF_W-1:0] TAP_HALF = 32'h0400_0000;
  localparam logic [COEF_W-1:0] TAP_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] TAP_MIN = 32'h8000_0000;
  localparam logic [COEF_W-1:0] TAP_ZERO = 32'h0000_0000;
  // Indexes past the last coefficient are ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_A2 + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = '1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7F_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'h80_0000;
  localparam longint STATE_MAX = (64'sd1 <<< (STATE_W - 1)) - 1;
  localparam longint STATE_MIN = -STATE_MAX - 1;
  localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_W - 1);

  typedef enum bit {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0] word;
    logic signed [SAMPLE_W-1:0] x;
    bit ch;
    bit typed;
    logic signed [SAMPLE_W-1:0] y;
  } dir_row_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    bit chan;
  } filtered_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  // Mirror of the coefficient registers and the per-channel delay pairs
  longint taps [0:4] = '{134217728, 0, 0, 0, 0};
  longint delay_one [0:1] = '{0, 0};
  longint delay_two [0:1] = '{0, 0};

  filtered_t awaited [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  dir_row_t directed [NUM_ROWS];

  biquad_tdf2_multichannel_filter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint saturate(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Run one sample through the channel's biquad and advance its delay pair
  function automatic logic signed [SAMPLE_W-1:0] filter_step(
      input logic signed [SAMPLE_W-1:0] x, input bit ch);
    longint xs, acc, y, r1, r2;
    xs = x;
    acc = taps[REG_B0] * xs + delay_one[ch] + ROUND_HALF;
    y = saturate(acc >>> FRAC_W, longint'(SAMPLE_MIN), longint'(SAMPLE_MAX));
    r1 = taps[REG_B1] * xs - taps[REG_A1] * y + delay_two[ch];
    r2 = taps[REG_B2] * xs - taps[REG_A2] * y;
    delay_one[ch] = saturate(r1, STATE_MIN, STATE_MAX);
    delay_two[ch] = saturate(r2, STATE_MIN, STATE_MAX);
    return y[SAMPLE_W-1:0];
  endfunction

  // Extremes, zero, full random, or a coefficient in a usable range
  function automatic logic [COEF_W-1:0] pick_tap(input bit tame, input bit feedback);
    int unsigned sel;
    sel = tame ? 3 : $urandom_range(0, 5);
    case (sel)
      0: return TAP_MAX;
      1: return TAP_MIN;
      2: return TAP_ZERO;
      5: return $urandom;
      default: begin
        if (feedback) return int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
        return int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
      end
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      1: return SAMPLE_W'(int'($urandom_range(0, 510)) - 255);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Drop valid and hold until every awaited sample has come back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] word);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_A2) taps[idx] = longint'($signed(word));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic feed_sample(input logic signed [SAMPLE_W-1:0] x, input bit ch,
                             input bit typed, input logic signed [SAMPLE_W-1:0] y_typed);
    filtered_t res;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= x;
    in_tuser <= ch;
    do @(posedge clk); while (!in_tready);
    res.sample = filter_step(x, ch);
    res.chan = ch;
    if (typed) res.sample = y_typed;
    awaited.push_back(res);
  endtask

  // Random backpressure on the result side
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Compare each result with the oldest awaited sample
  always @(posedge clk) begin
    filtered_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected item, expected none, got sample %0d channel %0d",
                 $time, $signed(out_tdata[SAMPLE_W-1:0]), out_tuser);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        if (out_tdata[SAMPLE_W-1:0] !== want.sample) begin
          $display("%0t: sample_out mismatch, expected %0d, got %0d", $time,
                   want.sample, $signed(out_tdata[SAMPLE_W-1:0]));
          mismatches++;
        end
        if (out_tuser !== want.chan) begin
          $display("%0t: channel_out mismatch, expected %0d, got %0d", $time,
                   want.chan, out_tuser);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no item moves on any channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    bit tame;

    directed = '{
      // after reset b0 is one and the state is zero: samples pass through
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, 24'sd0, 1'b0, 1'b1, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, SAMPLE_MAX, 1'b0, 1'b1, SAMPLE_MAX},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, SAMPLE_MIN, 1'b1, 1'b1, SAMPLE_MIN},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, 24'sd1, 1'b1, 1'b1, 24'sd1},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, -24'sd1, 1'b0, 1'b1, -24'sd1},
      // largest gain: output saturates
      '{ROW_WRITE, REG_B0, TAP_MAX, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, SAMPLE_MAX, 1'b0, 1'b1, SAMPLE_MAX},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, SAMPLE_MIN, 1'b1, 1'b1, SAMPLE_MIN},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, 24'sd0, 1'b1, 1'b1, 24'sd0},
      // most negative gain: saturates the other way
      '{ROW_WRITE, REG_B0, TAP_MIN, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MIN},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, SAMPLE_MIN, 1'b0, 1'b1, SAMPLE_MAX},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, 24'sd4, 1'b0, 1'b1, -24'sd64},
      // half gain: ties round toward plus infinity
      '{ROW_WRITE, REG_B0, TAP_HALF, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, 24'sd1, 1'b0, 1'b1, 24'sd1},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, -24'sd1, 1'b1, 1'b1, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, 24'sd3, 1'b1, 1'b1, 24'sd2},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, -24'sd3, 1'b0, 1'b1, -24'sd1},
      // writes past the last coefficient change nothing
      '{ROW_WRITE, REG_SPARE_FIRST, TAP_MAX, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_WRITE, REG_SPARE_LAST, TAP_MIN, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, 24'sd1, 1'b1, 1'b1, 24'sd1},
      // extreme taps drive the delay state into saturation
      '{ROW_WRITE, REG_B0, TAP_ONE, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_WRITE, REG_B1, TAP_MAX, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_WRITE, REG_B2, TAP_MAX, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_WRITE, REG_A1, TAP_MIN, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_WRITE, REG_A2, TAP_MIN, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, SAMPLE_MAX, 1'b0, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, SAMPLE_MAX, 1'b0, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, SAMPLE_MIN, 1'b0, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, SAMPLE_MAX, 1'b1, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, 24'sd0, 1'b0, 1'b0, 24'sd0},
      // a plain low-pass with channels interleaved
      '{ROW_WRITE, REG_B0, 32'h0088_0000, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_WRITE, REG_B1, 32'h0110_0000, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_WRITE, REG_B2, 32'h0088_0000, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_WRITE, REG_A1, 32'hF199_999A, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_WRITE, REG_A2, 32'h067A_E148, 24'sd0, 1'b0, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, 24'sd1000000, 1'b1, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, -24'sd500000, 1'b0, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, 24'sd0, 1'b1, 1'b0, 24'sd0},
      '{ROW_SAMPLE, REG_B0, TAP_ZERO, 24'sd0, 1'b0, 1'b0, 24'sd0}
    };

    // Hold reset low, then release it on a falling clock edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_WRITE) begin
        drain();
        write_reg(directed[i].idx, directed[i].word);
      end else begin
        feed_sample(directed[i].x, directed[i].ch, directed[i].typed, directed[i].y);
      end
    end

    // Random phases: new taps and a new idling pattern each time
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case (phase % 4)
        0: begin send_gap_pct = 0; sink_stall_pct = 0; end
        1: begin send_gap_pct = 67; sink_stall_pct = 0; end
        2: begin send_gap_pct = 0; sink_stall_pct = 67; end
        default: begin send_gap_pct = 20; sink_stall_pct = 20; end
      endcase
      tame = (phase == 0) || ($urandom_range(0, 2) == 0);
      write_reg(REG_B0, pick_tap(tame, 1'b0));
      write_reg(REG_B1, pick_tap(tame, 1'b0));
      write_reg(REG_B2, pick_tap(tame, 1'b0));
      write_reg(REG_A1, pick_tap(tame, 1'b1));
      write_reg(REG_A2, pick_tap(tame, 1'b0));
      if ($urandom_range(0, 1) == 1) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        feed_sample(pick_sample(), 1'($urandom_range(0, 1)), 1'b0, 24'sd0);
      end
    end

    // Let the pipeline empty, then report
    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: biquad_tdf2_multichannel_filter.f
+incdir+rtl
rtl/bqtdf2_pkg.sv
rtl/bqtdf2_mac_lane.sv
rtl/bqtdf2_delay_store.sv
rtl/biquad_tdf2_multichannel_filter.sv
dv/biquad_tdf2_multichannel_filter_test.sv
